// File: rtl/gf64m_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gf64m_pkg;

    localparam int unsigned GF_WIDTH   = 64;
    localparam int unsigned TAG_WIDTH  = 32;
    localparam int unsigned LEN_WIDTH  = 32;
    localparam int unsigned NB_WIDTH   = 4;
    localparam int unsigned IDX_WIDTH  = 2;
    localparam int unsigned BLK_BYTES  = GF_WIDTH / 8;
    // multiplier bits consumed per cycle by the shared GF unit
    localparam int unsigned MUL_DIGIT  = 8;
    localparam int unsigned MUL_STEPS  = GF_WIDTH / MUL_DIGIT;
    localparam int unsigned STEP_WIDTH = $clog2(MUL_STEPS);

    localparam logic [GF_WIDTH-1:0] GF_REDUCTION = 64'h0000_0000_0000_001b;
    localparam logic [GF_WIDTH-1:0] GF_TOP_BIT   = 64'h8000_0000_0000_0000;

    typedef enum logic [IDX_WIDTH-1:0] {
        CFG_KEY_P = 2'd0,
        CFG_KEY_Q = 2'd1,
        CFG_MASK  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_Q,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                start;
        logic [GF_WIDTH-1:0] op_a;
        logic [GF_WIDTH-1:0] op_b;
    } t_mul_req;

    typedef struct packed {
        logic                done;
        logic [GF_WIDTH-1:0] product;
    } t_mul_rsp;

endpackage

`default_nettype wire

// File: rtl/gf64m_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gf64m_in_if;
    import gf64m_pkg::*;
    logic                valid;
    logic                ready;
    logic [GF_WIDTH-1:0] block_data;
    logic [NB_WIDTH-1:0] valid_bytes;
    logic                last_block;

    modport source (output valid, block_data, valid_bytes, last_block, input ready);
    modport sink   (input valid, block_data, valid_bytes, last_block, output ready);
endinterface

interface gf64m_out_if;
    import gf64m_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TAG_WIDTH-1:0] mac_tag;

    modport source (output valid, mac_tag, input ready);
    modport sink   (input valid, mac_tag, output ready);
endinterface

interface gf64m_cfg_if;
    import gf64m_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IDX_WIDTH-1:0] reg_index;
    logic [GF_WIDTH-1:0]  wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/gf64_polynomial_mac.sv
// A block with data goes through a multiply by key P before input is ready again; a last block
//   adds a second multiply by Q before its tag is registered at the output.
// No new block is taken before the last one is through the shared GF(2^64) multiplier (8 bits/cycle).
// An empty non-last block is taken every cycle while the FSM is idle.
// Reset (synchronous, active low) clears keys, mask, accumulator, bit count and output valid.
`timescale 1ns / 1ps
`default_nettype none

module gf64_polynomial_mac
    import gf64m_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gf64m_in_if.sink    i_in,
    gf64m_out_if.source o_out,
    gf64m_cfg_if.sink   i_cfg
);

    t_state               r_state, n_state;
    logic [GF_WIDTH-1:0]  r_key_p, r_key_q;
    logic [TAG_WIDTH-1:0] r_mask;
    logic [GF_WIDTH-1:0]  r_acc,   n_acc;
    logic [LEN_WIDTH-1:0] r_len,   n_len;
    logic                 r_last,  n_last;
    logic [GF_WIDTH-1:0]  r_fin,   n_fin;
    logic                 r_ovalid, n_ovalid;
    logic [TAG_WIDTH-1:0] r_tag,   n_tag;

    t_mul_req             w_req;
    t_mul_rsp             w_rsp;

    logic                 w_in_beat;
    logic [NB_WIDTH-1:0]  w_nb;
    logic [GF_WIDTH-1:0]  w_data;
    logic [LEN_WIDTH:0]   w_sum;
    logic [LEN_WIDTH-1:0] w_len_new;

    gf64m_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_beat   = i_in.valid && i_in.ready;

    always_comb begin
        w_nb = (i_in.valid_bytes > NB_WIDTH'(BLK_BYTES)) ? NB_WIDTH'(BLK_BYTES)
                                                         : i_in.valid_bytes;
        // byte 0 sits in the top lane
        for (int j = 0; j < BLK_BYTES; j++) begin
            w_data[GF_WIDTH-1-8*j -: 8] = (NB_WIDTH'(j) < w_nb)
                                          ? i_in.block_data[GF_WIDTH-1-8*j -: 8] : 8'h00;
        end
        w_sum     = {1'b0, r_len} + (LEN_WIDTH+1)'({w_nb, 3'b000});
        w_len_new = w_sum[LEN_WIDTH] ? '1 : w_sum[LEN_WIDTH-1:0];
    end

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_len    = r_len;
        n_last   = r_last;
        n_fin    = r_fin;
        n_ovalid = r_ovalid;
        n_tag    = r_tag;
        w_req    = '{start: 1'b0, op_a: '0, op_b: '0};

        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_beat) begin
                    n_last = i_in.last_block;
                    if (w_nb != '0) begin
                        n_len   = w_len_new;
                        w_req   = '{start: 1'b1, op_a: r_acc ^ w_data, op_b: r_key_p};
                        n_state = ST_MUL_P;
                    end else if (i_in.last_block) begin
                        w_req   = '{start: 1'b1,
                                    op_a: r_acc ^ GF_WIDTH'(r_len), op_b: r_key_q};
                        n_state = ST_MUL_Q;
                    end
                end
            end
            ST_MUL_P: begin
                if (w_rsp.done) begin
                    n_acc = w_rsp.product;
                    if (r_last) begin
                        w_req   = '{start: 1'b1,
                                    op_a: w_rsp.product ^ GF_WIDTH'(r_len), op_b: r_key_q};
                        n_state = ST_MUL_Q;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MUL_Q: begin
                if (w_rsp.done) begin
                    n_fin   = w_rsp.product;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait for the output register to free up
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_tag    = r_fin[GF_WIDTH-1 -: TAG_WIDTH] ^ r_mask;
                    n_acc    = '0;
                    n_len    = '0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_acc    <= '0;
            r_len    <= '0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_acc    <= n_acc;
            r_len    <= n_len;
            r_last   <= n_last;
        end
        r_fin <= n_fin;
        r_tag <= n_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_p <= '0;
            r_key_q <= '0;
            r_mask  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.reg_index)
                CFG_KEY_P: r_key_p <= i_cfg.wdata;
                CFG_KEY_Q: r_key_q <= i_cfg.wdata;
                CFG_MASK:  r_mask  <= i_cfg.wdata[TAG_WIDTH-1:0];
                default:   ;
            endcase
        end
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.mac_tag = r_tag;

endmodule

`default_nettype wire

// File: rtl/gf64m_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module gf64m_mul
    import gf64m_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    typedef struct packed {
        logic [GF_WIDTH-1:0] acc;
        logic [GF_WIDTH-1:0] shift;
    } t_gf_pair;

    // one digit of the LSB-first shift-and-add multiply
    function automatic t_gf_pair gf_digit(input t_gf_pair st, input logic [MUL_DIGIT-1:0] bits);
        t_gf_pair r;
        r = st;
        for (int k = 0; k < MUL_DIGIT; k++) begin
            if (bits[k]) begin
                r.acc = r.acc ^ r.shift;
            end
            r.shift = {r.shift[GF_WIDTH-2:0], 1'b0}
                      ^ (((r.shift & GF_TOP_BIT) != '0) ? GF_REDUCTION : '0);
        end
        return r;
    endfunction

    logic                  r_busy,  n_busy;
    logic                  r_done,  n_done;
    logic [STEP_WIDTH-1:0] r_cnt,   n_cnt;
    logic [GF_WIDTH-1:0]   r_acc,   n_acc;
    logic [GF_WIDTH-1:0]   r_shift, n_shift;
    logic [GF_WIDTH-1:0]   r_b,     n_b;
    t_gf_pair              w_step;

    always_comb begin
        w_step = gf_digit('{acc: r_acc, shift: r_shift}, r_b[MUL_DIGIT-1:0]);
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_shift = r_shift;
        n_b     = r_b;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_acc   = '0;
            n_shift = i_req.op_a;
            n_b     = i_req.op_b;
        end else if (r_busy) begin
            n_acc   = w_step.acc;
            n_shift = w_step.shift;
            n_b     = r_b >> MUL_DIGIT;
            n_cnt   = r_cnt + 1'b1;
            if (r_cnt == STEP_WIDTH'(MUL_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc   <= n_acc;
        r_shift <= n_shift;
        r_b     <= n_b;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

`default_nettype wire

// File: rtl/gf64m_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gf64m_checker
    import gf64m_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_in_last,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [TAG_WIDTH-1:0] i_out_tag
);

    logic w_in_beat;
    assign w_in_beat = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_tag))
        else $error("tag beat dropped or changed while stalled");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_in_last |=> !i_in_ready)
        else $error("input ready right after a last block");

    a_no_instant_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(w_in_beat))
        else $error("tag appeared directly after an input beat");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind gf64_polynomial_mac gf64m_checker u_gf64m_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_block),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_tag   (o_out.mac_tag)
);

`default_nettype wire

// File: verif/gf64_polynomial_mac_tb.sv
`timescale 1ns / 1ps

module gf64_polynomial_mac_tb;
    import gf64m_pkg::*;

    localparam int unsigned TAIL_CYCLES  = 32;
    localparam int unsigned RANDOM_ITEMS = 1600;
    localparam int unsigned CHUNK_ITEMS  = 160;

    typedef struct {
        logic [GF_WIDTH-1:0] data;
        logic [NB_WIDTH-1:0] nbytes;
        logic                last;
        logic                drain;  // hold until every pending tag has come back
    } t_blk_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    gf64m_in_if  blk_bus ();
    gf64m_out_if tag_bus ();
    gf64m_cfg_if cfg_bus ();

    logic                 blk_valid  = 1'b0;
    logic [GF_WIDTH-1:0]  blk_data   = '0;
    logic [NB_WIDTH-1:0]  blk_nbytes = '0;
    logic                 blk_last   = 1'b0;
    logic                 tag_ready  = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic [IDX_WIDTH-1:0] cfg_index  = '0;
    logic [GF_WIDTH-1:0]  cfg_wdata  = '0;

    assign blk_bus.valid       = blk_valid;
    assign blk_bus.block_data  = blk_data;
    assign blk_bus.valid_bytes = blk_nbytes;
    assign blk_bus.last_block  = blk_last;
    assign tag_bus.ready       = tag_ready;
    assign cfg_bus.valid       = cfg_valid;
    assign cfg_bus.reg_index   = cfg_index;
    assign cfg_bus.wdata       = cfg_wdata;

    gf64_polynomial_mac u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (blk_bus),
        .o_out   (tag_bus),
        .i_cfg   (cfg_bus)
    );

    t_blk_item             pending_blocks[$];
    logic [TAG_WIDTH-1:0]  expected_tags[$];

    // predictor state
    logic [GF_WIDTH-1:0]   key_p_model;
    logic [GF_WIDTH-1:0]   key_q_model;
    logic [TAG_WIDTH-1:0]  mask_model;
    logic [GF_WIDTH-1:0]   acc_state;
    logic [LEN_WIDTH-1:0]  bits_state;

    logic                  no_idle       = 1'b0;
    int                    src_gap;
    int                    sink_gap;
    int                    failures      = 0;
    int                    tags_checked  = 0;
    int                    blocks_taken  = 0;
    int                    cfg_settings  = 0;
    int                    queued_items  = 0;
    t_blk_item             drv_item;
    logic [TAG_WIDTH-1:0]  want_tag;
    int                    short_counts[5] = '{1, 2, 4, 6, 7};

    function automatic logic [GF_WIDTH-1:0] gf64_product(input logic [GF_WIDTH-1:0] a,
                                                         input logic [GF_WIDTH-1:0] b);
        logic [GF_WIDTH-1:0] prod;
        logic [GF_WIDTH-1:0] run;
        prod = '0;
        run  = a;
        for (int k = 0; k < GF_WIDTH; k++) begin
            if (b[k])
                prod ^= run;
            if ((run & GF_TOP_BIT) != 0)
                run = (run << 1) ^ GF_REDUCTION;
            else
                run = run << 1;
        end
        return prod;
    endfunction

    task automatic absorb_block(input logic [GF_WIDTH-1:0] data,
                                input logic [NB_WIDTH-1:0] nb_raw,
                                input logic last);
        int unsigned          nb;
        logic [GF_WIDTH-1:0]  kept;
        logic [LEN_WIDTH:0]   sum;
        logic [GF_WIDTH-1:0]  fin;
        nb = (nb_raw > BLK_BYTES) ? BLK_BYTES : nb_raw;
        if (nb != 0) begin
            kept = (nb == BLK_BYTES) ? data : data & ~({GF_WIDTH{1'b1}} >> (8 * nb));
            acc_state = gf64_product(acc_state ^ kept, key_p_model);
            sum = {1'b0, bits_state} + (LEN_WIDTH + 1)'(8 * nb);
            bits_state = sum[LEN_WIDTH] ? '1 : sum[LEN_WIDTH-1:0];
        end
        if (last) begin
            fin = gf64_product(acc_state ^ {{(GF_WIDTH - LEN_WIDTH){1'b0}}, bits_state},
                               key_q_model);
            expected_tags.push_back(fin[GF_WIDTH-1 -: TAG_WIDTH] ^ mask_model);
            acc_state  = '0;
            bits_state = '0;
        end
    endtask

    // register shadow
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_p_model <= '0;
            key_q_model <= '0;
            mask_model  <= '0;
        end else if (cfg_valid && cfg_bus.ready) begin
            cfg_settings <= cfg_settings + 1;
            case (t_cfg_idx'(cfg_index))
                CFG_KEY_P: key_p_model <= cfg_wdata;
                CFG_KEY_Q: key_q_model <= cfg_wdata;
                CFG_MASK:  mask_model  <= cfg_wdata[TAG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // block driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blk_valid  <= 1'b0;
            blk_data   <= '0;
            blk_nbytes <= '0;
            blk_last   <= 1'b0;
            src_gap    = 0;
            acc_state  = '0;
            bits_state = '0;
        end else begin
            if (blk_valid && blk_bus.ready) begin
                absorb_block(blk_data, blk_nbytes, blk_last);
                blocks_taken++;
            end
            if (!blk_valid || blk_bus.ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    blk_valid <= 1'b0;
                end else if (pending_blocks.size() != 0 &&
                             !(pending_blocks[0].drain && expected_tags.size() != 0)) begin
                    drv_item = pending_blocks.pop_front();
                    blk_data   <= drv_item.data;
                    blk_nbytes <= drv_item.nbytes;
                    blk_last   <= drv_item.last;
                    blk_valid  <= 1'b1;
                    src_gap = no_idle ? 0 : $urandom_range(0, 6);
                end else begin
                    blk_valid <= 1'b0;
                end
            end
        end
    end

    // tag monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tag_ready <= 1'b0;
            sink_gap  = 0;
        end else begin
            if (tag_bus.valid && tag_ready) begin
                if (expected_tags.size() == 0) begin
                    $error("mac_tag: expected none, actual %h", tag_bus.mac_tag);
                    failures++;
                end else begin
                    want_tag = expected_tags.pop_front();
                    tags_checked++;
                    if (tag_bus.mac_tag !== want_tag) begin
                        $error("mac_tag: expected %h, actual %h", want_tag, tag_bus.mac_tag);
                        failures++;
                    end
                end
                sink_gap = no_idle ? 0 : $urandom_range(0, 6);
            end else if (sink_gap != 0) begin
                sink_gap--;
            end
            tag_ready <= (sink_gap == 0);
        end
    end

    function automatic logic [GF_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return GF_TOP_BIT;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_block(input logic [GF_WIDTH-1:0] data, input int nb,
                              input logic last, input logic drain);
        t_blk_item it;
        it.data   = data;
        it.nbytes = NB_WIDTH'(nb);
        it.last   = last;
        it.drain  = drain;
        pending_blocks.push_back(it);
        if (nb != 0 || last)
            queued_items++;
    endtask

    // mostly well-formed messages; noisy ones carry odd byte counts
    task automatic push_message();
        int   nblocks;
        int   nb;
        logic noisy;
        logic last;
        nblocks = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        noisy   = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < nblocks; i++) begin
            last = (i == nblocks - 1);
            nb   = last ? $urandom_range(0, 8) : 8;
            if (noisy && $urandom_range(0, 3) == 0)
                nb = $urandom_range(0, 15);
            push_block(rand_word(), nb, last, (i == 0) && ($urandom_range(0, 29) == 0));
        end
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [GF_WIDTH-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_keys(input logic [GF_WIDTH-1:0] p, input logic [GF_WIDTH-1:0] q,
                             input logic [GF_WIDTH-1:0] mask);
        cfg_write(CFG_KEY_P, p);
        cfg_write(CFG_KEY_Q, q);
        cfg_write(CFG_MASK, mask & {{(GF_WIDTH - TAG_WIDTH){1'b0}}, {TAG_WIDTH{1'b1}}});
    endtask

    // empty non-last blocks give no tag, so let the multiplier finish afterwards
    task automatic wait_idle();
        while (pending_blocks.size() != 0 || blk_valid || expected_tags.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        #10_000_000;
        $display("gf64_polynomial_mac regression: fail");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_keys({$urandom, $urandom}, {$urandom, $urandom}, {32'b0, $urandom});
        push_block(rand_word(), 0, 1'b1, 1'b0);          // zero-length message
        push_block('1, 8, 1'b1, 1'b0);
        push_block('0, 8, 1'b1, 1'b0);
        push_block(rand_word(), 8, 1'b0, 1'b0);          // short block mid-message,
        push_block(rand_word(), 3, 1'b0, 1'b0);          // then an empty one
        push_block(rand_word(), 0, 1'b0, 1'b0);
        push_block(rand_word(), 5, 1'b1, 1'b0);
        foreach (short_counts[i])
            push_block('1, short_counts[i], 1'b1, 1'b0);
        push_block(rand_word(), 9, 1'b1, 1'b0);          // count above eight
        push_block('1, 15, 1'b1, 1'b0);
        push_block(rand_word(), 8, 1'b0, 1'b0);          // empty last after data
        push_block(rand_word(), 0, 1'b1, 1'b0);
        push_block(rand_word(), 0, 1'b0, 1'b0);          // two-item empty message
        push_block(rand_word(), 0, 1'b1, 1'b0);
        wait_idle();

        load_keys('1, '1, '1);
        repeat (6) push_message();
        wait_idle();
        load_keys('0, '0, '0);
        repeat (6) push_message();
        wait_idle();
        load_keys(64'h1, GF_TOP_BIT, 64'hFFFF_0000);
        repeat (6) push_message();
        wait_idle();

        queued_items = 0;
        while (queued_items < RANDOM_ITEMS) begin
            load_keys(rand_word(), rand_word(),
                      ($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF : {32'b0, $urandom});
            no_idle = ($urandom_range(0, 3) == 0);
            while (pending_blocks.size() < CHUNK_ITEMS)
                push_message();
            wait_idle();
        end

        if (expected_tags.size() != 0) begin
            $error("mac_tag: expected %0d more, actual none", expected_tags.size());
            failures++;
        end
        $display("covered %0d blocks over %0d register writes, %0d tags compared",
                 blocks_taken, cfg_settings, tags_checked);
        if (failures == 0)
            $display("gf64_polynomial_mac regression: pass");
        else
            $display("gf64_polynomial_mac regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/gf64m_pkg.sv
rtl/gf64m_if.sv
rtl/gf64m_mul.sv
rtl/gf64_polynomial_mac.sv
rtl/gf64m_checker.sv
verif/gf64_polynomial_mac_tb.sv
